FILE: src/tisp_pkg.sv
// tape image stream parser: shared constants, codes, result and status types
// no dependencies; compiled first
package tisp_pkg;

  localparam int LA_DEPTH  = 16;
  localparam int FILL_W    = $clog2(LA_DEPTH + 1);
  localparam int OFFSET_W  = 32;
  localparam int SYNC_LEN  = 8;
  localparam int TYPE_LEN  = 10;
  localparam int NAME_LEN  = 6;
  localparam int HDR_LEN   = TYPE_LEN + NAME_LEN;
  localparam int ADDR_LEN  = 6;
  localparam int LEFT_W    = 4;
  localparam int PASSES    = 5;

  localparam logic [SYNC_LEN-1:0][7:0] SYNC_PATTERN = {
    8'h74, 8'h7D, 8'h13, 8'hCC, 8'hBA, 8'hDE, 8'hA6, 8'h1F
  };
  localparam logic [7:0] TYPE_TEXT  = 8'hEA;
  localparam logic [7:0] TYPE_BIN   = 8'hD0;
  localparam logic [7:0] TYPE_TOKEN = 8'hD3;
  localparam logic [7:0] TEXT_EOF   = 8'h1A;

  typedef enum logic [2:0] {
    ROLE_SYNC     = 3'd0,
    ROLE_TYPE     = 3'd1,
    ROLE_NAME     = 3'd2,
    ROLE_ADDR     = 3'd3,
    ROLE_PAYLOAD  = 3'd4,
    ROLE_EOF      = 3'd5,
    ROLE_PAD      = 3'd6,
    ROLE_UNPARSED = 3'd7
  } role_e;

  typedef enum logic [2:0] {
    KIND_TEXT   = 3'd0,
    KIND_BIN    = 3'd1,
    KIND_TOKEN  = 3'd2,
    KIND_CUSTOM = 3'd3,
    KIND_NONE   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SYNC   = 3'd1,
    ST_TRUNC     = 3'd2,
    ST_NO_SYNC2  = 3'd3,
    ST_NO_EOF    = 3'd4
  } status_e;

  typedef logic [TYPE_LEN-1:0][7:0] head_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              emit;
    logic              last;
  } win_stat_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic [OFFSET_W-1:0] byte_offset;
    role_e               byte_role;
    kind_e               file_kind;
    logic [15:0]         file_number;
    logic [7:0]          block_number;
    logic [1:0]          address_slot;
    logic [15:0]         address_word;
    status_e             parse_status;
    logic                last_result;
  } result_t;

  function automatic logic type_run(head_t h, logic [7:0] v);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < TYPE_LEN; i++) begin
      if (h[i] != v) hit = 1'b0;
    end
    return hit;
  endfunction

endpackage

FILE: src/tisp_intf.sv
// tape image stream parser: byte request and result request channels
// depends on tisp_pkg for field widths
interface tisp_byte_if;
  import tisp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_image;

  modport source(output valid, data_byte, end_of_image, input ready);
  modport sink(input valid, data_byte, end_of_image, output ready);
endinterface

interface tisp_result_if;
  import tisp_pkg::*;
  logic                valid;
  logic                ready;
  logic [7:0]          out_byte;
  logic [OFFSET_W-1:0] byte_offset;
  logic [2:0]          byte_role;
  logic [2:0]          file_kind;
  logic [15:0]         file_number;
  logic [7:0]          block_number;
  logic [1:0]          address_slot;
  logic [15:0]         address_word;
  logic [2:0]          parse_status;
  logic                last_result;

  modport source(output valid, out_byte, byte_offset, byte_role, file_kind, file_number,
                 block_number, address_slot, address_word, parse_status, last_result,
                 input ready);
  modport sink(input valid, out_byte, byte_offset, byte_role, file_kind, file_number,
               block_number, address_slot, address_word, parse_status, last_result,
               output ready);
endinterface

FILE: src/tisp_window.sv
// tape image stream parser: look-ahead shift window with fill count and flush
// depends on tisp_pkg
module tisp_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          push_byte_i,
  input  logic                push_end_i,
  input  logic                pop_i,
  output logic                can_push_o,
  output tisp_pkg::head_t     head_o,
  output tisp_pkg::win_stat_t stat_o
);
  import tisp_pkg::*;

  logic [LA_DEPTH-1:0][7:0] win_q, win_d;
  logic [FILL_W-1:0]        fill_q, fill_d;
  logic [FILL_W-1:0]        wr_pos;
  logic                     flush_q, flush_d;

  assign wr_pos = fill_q - FILL_W'(pop_i);

  always_comb begin
    win_d = win_q;
    if (pop_i) begin
      for (int i = 0; i < LA_DEPTH - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
    end
    if (push_i) begin
      for (int i = 0; i < LA_DEPTH; i++) begin
        if (wr_pos == FILL_W'(i)) win_d[i] = push_byte_i;
      end
    end
  end

  assign fill_d = fill_q + FILL_W'(push_i) - FILL_W'(pop_i);

  always_comb begin
    flush_d = flush_q;
    if (push_i && push_end_i) flush_d = 1'b1;
    else if (pop_i && stat_o.last) flush_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      flush_q <= flush_d;
    end
  end

  assign head_o      = win_q[TYPE_LEN-1:0];
  assign stat_o.fill = fill_q;
  assign stat_o.emit = flush_q ? (fill_q != '0) : (fill_q == FILL_W'(LA_DEPTH));
  assign stat_o.last = flush_q && (fill_q == FILL_W'(1));
  assign can_push_o  = !flush_q && ((fill_q < FILL_W'(LA_DEPTH)) || pop_i);

endmodule

FILE: src/tisp_parser.sv
// tape image stream parser: container state machine and byte classifier
// depends on tisp_pkg; fed by tisp_window
module tisp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  tisp_pkg::head_t     head_i,
  input  tisp_pkg::win_stat_t stat_i,
  output tisp_pkg::result_t   res_o
);
  import tisp_pkg::*;

  typedef enum logic [3:0] {
    M_TOP      = 4'd0,
    M_SYNC     = 4'd1,
    M_TYPE     = 4'd2,
    M_TYPEB    = 4'd3,
    M_NAME     = 4'd4,
    M_DATA_HDR = 4'd5,
    M_ADDR_CHK = 4'd6,
    M_ADDR     = 4'd7,
    M_PAYLOAD  = 4'd8,
    M_ASC_HDR  = 4'd9,
    M_TEXT     = 4'd10,
    M_PAD      = 4'd11,
    M_STOP     = 4'd12
  } mode_e;

  mode_e               mode_q, mode_d;
  logic [LEFT_W-1:0]   left_q, left_d;
  kind_e               kind_q, kind_d;
  logic [15:0]         fcnt_q, fcnt_d;
  logic [7:0]          bcnt_q, bcnt_d;
  logic [7:0]          alo_q, alo_d;
  status_e             stat_q, stat_d;
  logic [OFFSET_W-1:0] pos_q;

  logic        sync_front;
  logic        run_text, run_bin, run_token;
  logic        done;
  role_e       role;
  logic [1:0]  slot;
  logic [15:0] word;
  logic [2:0]  idx;
  logic [7:0]  b;

  assign b          = head_i[0];
  assign sync_front = (stat_i.fill >= FILL_W'(SYNC_LEN)) &&
                      (head_i[SYNC_LEN-1:0] == SYNC_PATTERN);
  assign run_text   = type_run(head_i, TYPE_TEXT);
  assign run_bin    = type_run(head_i, TYPE_BIN);
  assign run_token  = type_run(head_i, TYPE_TOKEN);

  always_comb begin
    mode_d = mode_q;
    left_d = left_q;
    kind_d = kind_q;
    fcnt_d = fcnt_q;
    bcnt_d = bcnt_q;
    alo_d  = alo_q;
    stat_d = stat_q;
    role   = ROLE_UNPARSED;
    slot   = '0;
    word   = '0;
    idx    = '0;
    done   = 1'b0;
    for (int p = 0; p < PASSES; p++) begin
      if (!done) begin
        unique case (mode_d)
          M_TOP: begin
            if (sync_front) begin
              if (kind_d != KIND_NONE && fcnt_d != 16'hFFFF) fcnt_d = fcnt_d + 16'd1;
              kind_d = KIND_NONE;
              bcnt_d = '0;
              mode_d = M_SYNC;
              left_d = LEFT_W'(SYNC_LEN);
            end else begin
              if (kind_d == KIND_NONE && stat_d == ST_OK) stat_d = ST_NO_SYNC;
              mode_d = M_STOP;
            end
          end
          M_SYNC: begin
            if (left_d != '0) left_d = left_d - LEFT_W'(1);
            if (left_d == '0) begin
              if (bcnt_d == '0)            mode_d = M_TYPE;
              else if (kind_d == KIND_BIN)  mode_d = M_ADDR_CHK;
              else if (kind_d == KIND_TEXT) mode_d = M_TEXT;
              else                          mode_d = M_PAYLOAD;
            end
            role = ROLE_SYNC;
            done = 1'b1;
          end
          M_TYPE: begin
            if (stat_i.fill < FILL_W'(TYPE_LEN)) begin
              if (stat_d == ST_OK) stat_d = ST_TRUNC;
              mode_d = M_STOP;
            end else if (run_text || run_bin || run_token) begin
              if (stat_i.fill < FILL_W'(HDR_LEN)) begin
                if (stat_d == ST_OK) stat_d = ST_TRUNC;
                mode_d = M_STOP;
              end else begin
                kind_d = run_text ? KIND_TEXT : (run_bin ? KIND_BIN : KIND_TOKEN);
                mode_d = M_TYPEB;
                left_d = LEFT_W'(TYPE_LEN);
              end
            end else begin
              kind_d = KIND_CUSTOM;
              mode_d = M_PAYLOAD;
            end
          end
          M_TYPEB: begin
            if (left_d != '0) left_d = left_d - LEFT_W'(1);
            if (left_d == '0) begin
              mode_d = M_NAME;
              left_d = LEFT_W'(NAME_LEN);
            end
            role = ROLE_TYPE;
            done = 1'b1;
          end
          M_NAME: begin
            if (left_d != '0) left_d = left_d - LEFT_W'(1);
            if (left_d == '0) mode_d = (kind_d == KIND_TEXT) ? M_ASC_HDR : M_DATA_HDR;
            role = ROLE_NAME;
            done = 1'b1;
          end
          M_DATA_HDR: begin
            if (sync_front) begin
              if (bcnt_d != 8'hFF) bcnt_d = bcnt_d + 8'd1;
              mode_d = M_SYNC;
              left_d = LEFT_W'(SYNC_LEN);
            end else begin
              if (stat_d == ST_OK) stat_d = ST_NO_SYNC2;
              mode_d = M_STOP;
            end
          end
          M_ADDR_CHK: begin
            if (stat_i.fill < FILL_W'(ADDR_LEN)) begin
              if (stat_d == ST_OK) stat_d = ST_TRUNC;
              mode_d = M_STOP;
            end else begin
              mode_d = M_ADDR;
              left_d = LEFT_W'(ADDR_LEN);
            end
          end
          M_ADDR: begin
            idx = 3'(LEFT_W'(ADDR_LEN) - left_d);
            if (idx[0]) begin
              slot = idx[2:1] + 2'd1;
              word = {b, alo_d};
            end else begin
              alo_d = b;
            end
            if (left_d != '0) left_d = left_d - LEFT_W'(1);
            if (left_d == '0) mode_d = M_PAYLOAD;
            role = ROLE_ADDR;
            done = 1'b1;
          end
          M_PAYLOAD: begin
            if (sync_front) begin
              mode_d = M_TOP;
            end else begin
              role = ROLE_PAYLOAD;
              done = 1'b1;
            end
          end
          M_ASC_HDR: begin
            if (sync_front) begin
              if (bcnt_d != 8'hFF) bcnt_d = bcnt_d + 8'd1;
              mode_d = M_SYNC;
              left_d = LEFT_W'(SYNC_LEN);
            end else begin
              if (stat_d == ST_OK) stat_d = ST_NO_EOF;
              mode_d = M_STOP;
            end
          end
          M_TEXT: begin
            if (sync_front) begin
              mode_d = M_ASC_HDR;
            end else if (b == TEXT_EOF) begin
              mode_d = M_PAD;
              role   = ROLE_EOF;
              done   = 1'b1;
            end else begin
              role = ROLE_PAYLOAD;
              done = 1'b1;
            end
          end
          M_PAD: begin
            if (sync_front) begin
              mode_d = M_TOP;
            end else begin
              role = ROLE_PAD;
              done = 1'b1;
            end
          end
          default: begin
            mode_d = M_STOP;
            role   = ROLE_UNPARSED;
            done   = 1'b1;
          end
        endcase
      end
    end

    // checks that only the end of the image can reveal
    if (stat_i.last && stat_d == ST_OK) begin
      priority case (mode_d)
        M_TYPE, M_ADDR_CHK: stat_d = ST_TRUNC;
        M_DATA_HDR:         stat_d = ST_NO_SYNC2;
        M_ASC_HDR, M_TEXT:  stat_d = ST_NO_EOF;
        default:            stat_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_TOP;
      left_q <= '0;
      kind_q <= KIND_NONE;
      fcnt_q <= '0;
      bcnt_q <= '0;
      alo_q  <= '0;
      stat_q <= ST_OK;
      pos_q  <= '0;
    end else if (step_i) begin
      if (stat_i.last) begin
        mode_q <= M_TOP;
        left_q <= '0;
        kind_q <= KIND_NONE;
        fcnt_q <= '0;
        bcnt_q <= '0;
        alo_q  <= '0;
        stat_q <= ST_OK;
        pos_q  <= '0;
      end else begin
        mode_q <= mode_d;
        left_q <= left_d;
        kind_q <= kind_d;
        fcnt_q <= fcnt_d;
        bcnt_q <= bcnt_d;
        alo_q  <= alo_d;
        stat_q <= stat_d;
        pos_q  <= pos_q + OFFSET_W'(1);
      end
    end
  end

  always_comb begin
    res_o.out_byte     = b;
    res_o.byte_offset  = pos_q;
    res_o.byte_role    = role;
    res_o.file_kind    = kind_d;
    res_o.file_number  = fcnt_d;
    res_o.block_number = bcnt_d;
    res_o.address_slot = slot;
    res_o.address_word = word;
    res_o.parse_status = stat_d;
    res_o.last_result  = stat_i.last;
  end

endmodule

FILE: src/tape_image_stream_parser.sv
// tape image stream parser: top level with result register
// depends on tisp_pkg, tisp_intf, tisp_window, tisp_parser
//
// byte_i takes one image byte per request, end_of_image high on the final byte.
// result_o gives one tagged byte per request: role, file kind, file and block
// numbers, completed address word, and parse status.
// bytes pass through a 16-byte look-ahead window; the first result of an image
// appears once 16 bytes are held, or after end_of_image; each byte is registered
// in the window and then in the result register.
// throughput is one byte per cycle unless result_o stalls: the window shifts
// and the classifier and result register update in the same cycle, set by the
// single window read. after end_of_image the window drains one result per cycle
// unless result_o stalls, up to 16 results, with byte_i.ready low; the final
// result carries last_result, and all parse state returns to its reset values
// for the next image. when result_o stalls, the held result stays put and
// byte_i keeps accepting until the window is full.
// reset clears the window fill, counters and parse state; no clearing pass.
module tape_image_stream_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  tisp_byte_if.sink     byte_i,
  tisp_result_if.source result_o
);
  import tisp_pkg::*;

  head_t     head;
  win_stat_t wstat;
  result_t   res;
  result_t   out_q;
  logic      out_valid_q;
  logic      out_free;
  logic      pop;
  logic      push;
  logic      can_push;

  assign out_free     = !out_valid_q || result_o.ready;
  assign pop          = wstat.emit && out_free;
  assign push         = byte_i.valid && can_push;
  assign byte_i.ready = can_push;

  tisp_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_byte_i (byte_i.data_byte),
    .push_end_i  (byte_i.end_of_image),
    .pop_i       (pop),
    .can_push_o  (can_push),
    .head_o      (head),
    .stat_o      (wstat)
  );

  tisp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (pop),
    .head_i (head),
    .stat_i (wstat),
    .res_o  (res)
  );

  always_ff @(posedge clk_i) begin
    if (pop) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.out_byte     = out_q.out_byte;
  assign result_o.byte_offset  = out_q.byte_offset;
  assign result_o.byte_role    = out_q.byte_role;
  assign result_o.file_kind    = out_q.file_kind;
  assign result_o.file_number  = out_q.file_number;
  assign result_o.block_number = out_q.block_number;
  assign result_o.address_slot = out_q.address_slot;
  assign result_o.address_word = out_q.address_word;
  assign result_o.parse_status = out_q.parse_status;
  assign result_o.last_result  = out_q.last_result;

endmodule
